[rtl/core/stdds_pkg.sv]
// stdds_pkg: shared constants, register codes, gain bundle type and the
// quarter-wave cosine table entry function for the stereo tone generator
// depends on nothing
package stdds_pkg;

    // default sizes handed to the top level
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // fixed field widths
    localparam int STEP_BITS     = 32;
    localparam int GAIN_BITS     = 15;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    // cosine table: unsigned Q1.30, value range 0 .. 2^30
    localparam int ROM_FRAC  = 30;
    localparam int ROM_BITS  = ROM_FRAC + 1;
    localparam int PROD_BITS = GAIN_BITS + ROM_BITS;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ROM_ONE     = 64'd1 << ROM_FRAC;
    localparam int          TAYLOR_TERMS = 12;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEFT_STEP,
        CFG_RIGHT_STEP,
        CFG_LEFT_GAIN,
        CFG_RIGHT_GAIN
    } t_cfg_reg;

    // channel gains, front to back
    typedef struct packed {
        logic [GAIN_BITS-1:0] left_gain;
        logic [GAIN_BITS-1:0] right_gain;
    } t_gain_pair;

    // unsigned quotient by restoring long division; evaluated at elaboration only
    function automatic logic [63:0] quotient(input logic [63:0] num,
                                             input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos(pi/2 * q / 2^addr_bits) by a truncated integer taylor series,
    // clamped to [0, 1]; evaluated at elaboration only
    function automatic logic [ROM_BITS-1:0] cos_entry(input int unsigned q,
                                                      input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] den;
        longint      sum;
        x   = (HALF_PI_Q30 * 64'(q)) >> addr_bits;
        x2  = (x * x) >> ROM_FRAC;
        mag = ROM_ONE;
        sum = longint'(ROM_ONE);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            den = 64'((2 * k - 1) * (2 * k));
            mag = quotient((mag * x2) >> ROM_FRAC, den);
            if ((k & 1) == 1) begin
                sum = sum - longint'(mag);
            end else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ROM_ONE)) begin
            sum = longint'(ROM_ONE);
        end
        return ROM_BITS'(sum);
    endfunction

endpackage

[rtl/core/stdds_tick_if.sv]
// stdds_tick_if: request channel carrying one tick per beat
// depends on nothing
interface stdds_tick_if;
    logic valid;
    logic ready;
    logic is_tick;

    modport source (output valid, output is_tick, input ready);
    modport sink   (input valid, input is_tick, output ready);
endinterface

[rtl/core/stdds_sample_if.sv]
// stdds_sample_if: result channel carrying one stereo sample pair per beat
// depends on stdds_pkg for the default sample width
interface stdds_sample_if
    import stdds_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          bad_message;

    modport source (output valid, output left_sample, output right_sample,
                    output bad_message, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input bad_message, output ready);
endinterface

[rtl/core/stdds_front.sv]
// stdds_front: configuration registers, phase accumulators and tick
// classification; pushes one table lookup job per accepted beat
// depends on stdds_pkg and stdds_tick_if
module stdds_front
    import stdds_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    stdds_tick_if.sink                 i_tick,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data,
    output t_gain_pair                 o_gain,
    output logic                       o_q_valid,
    input  logic                       i_q_ready,
    output logic [2*(TABLE_ADDR_BITS+2):0] o_q_data
);

    localparam int TOP_BITS = TABLE_ADDR_BITS + 2;

    logic [STEP_BITS-1:0]  r_left_step;
    logic [STEP_BITS-1:0]  r_right_step;
    t_gain_pair            r_gain;
    logic [PHASE_BITS-1:0] r_left_phase;
    logic [PHASE_BITS-1:0] r_right_phase;
    logic [PHASE_BITS-1:0] n_left_phase;
    logic [PHASE_BITS-1:0] n_right_phase;
    logic                  w_accept;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_step  <= '0;
            r_right_step <= '0;
            r_gain       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_LEFT_STEP:  r_left_step       <= i_cfg_data[STEP_BITS-1:0];
                CFG_RIGHT_STEP: r_right_step      <= i_cfg_data[STEP_BITS-1:0];
                CFG_LEFT_GAIN:  r_gain.left_gain  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RIGHT_GAIN: r_gain.right_gain <= i_cfg_data[GAIN_BITS-1:0];
            endcase
        end
    end

    // handshake: the queue decides
    assign w_accept     = i_tick.valid && i_q_ready;
    assign i_tick.ready = i_q_ready;
    assign o_q_valid    = i_tick.valid;

    // job: bad flag, then the quadrant and table bits of each phase
    assign o_q_data = {!i_tick.is_tick,
                       r_left_phase[PHASE_BITS-1 -: TOP_BITS],
                       r_right_phase[PHASE_BITS-1 -: TOP_BITS]};

    // phase advance, wrapping at a full turn
    always_comb begin
        n_left_phase  = r_left_phase + PHASE_BITS'(r_left_step);
        n_right_phase = r_right_phase + PHASE_BITS'(r_right_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_phase  <= '0;
            r_right_phase <= '0;
        end else if (w_accept && i_tick.is_tick) begin
            r_left_phase  <= n_left_phase;
            r_right_phase <= n_right_phase;
        end
    end

    assign o_gain = r_gain;

endmodule

[rtl/core/stdds_queue.sv]
// stdds_queue: small register queue that decouples the front from the back
// depends on nothing from the package
module stdds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_push;
    logic                w_pop;

    assign o_push_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/stdds_back.sv]
// stdds_back: three stage sample pipeline: cosine table read, gain
// multiply, then rounding, sign and output register
// depends on stdds_pkg and stdds_sample_if
module stdds_back
    import stdds_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_gain_pair                     i_gain,
    input  logic                           i_q_valid,
    output logic                           o_q_ready,
    input  logic [2*(TABLE_ADDR_BITS+2):0] i_q_data,
    stdds_sample_if.source                 o_sample
);

    localparam int TOP_BITS   = TABLE_ADDR_BITS + 2;
    localparam int ADDR_BITS  = TABLE_ADDR_BITS + 1;
    localparam int ROM_DEPTH  = (1 << TABLE_ADDR_BITS) + 1;
    localparam int SHIFT      = PROD_BITS - SAMPLE_BITS;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (SHIFT - 1);

    typedef logic [ROM_DEPTH-1:0][ROM_BITS-1:0] t_rom_img;

    function automatic t_rom_img build_rom();
        t_rom_img img;
        for (int q = 0; q < ROM_DEPTH; q++) begin
            img[q] = cos_entry(q, TABLE_ADDR_BITS);
        end
        img[ROM_DEPTH-1] = '0;
        return img;
    endfunction

    // table address for one channel: mirrored in odd quadrants
    function automatic logic [ADDR_BITS-1:0] table_addr(input logic [TOP_BITS-1:0] top);
        logic [ADDR_BITS-1:0] q;
        q = {1'b0, top[TABLE_ADDR_BITS-1:0]};
        return top[TABLE_ADDR_BITS] ? (ADDR_BITS'(1) << TABLE_ADDR_BITS) - q : q;
    endfunction

    // rounded magnitude with the quadrant sign applied
    function automatic logic [SAMPLE_BITS-1:0] finish(input logic [PROD_BITS-1:0] prod,
                                                      input logic neg);
        logic [PROD_BITS:0]     rounded;
        logic [SAMPLE_BITS-1:0] mag;
        rounded = {1'b0, prod} + ROUND_HALF;
        mag     = rounded[SHIFT +: SAMPLE_BITS];
        return neg ? (~mag) + SAMPLE_BITS'(1) : mag;
    endfunction

    localparam t_rom_img ROM_IMG = build_rom();

    logic [TOP_BITS-1:0]  w_top_l;
    logic [TOP_BITS-1:0]  w_top_r;
    logic [ADDR_BITS-1:0] w_addr_l;
    logic [ADDR_BITS-1:0] w_addr_r;
    logic                 w_s1_load;
    logic                 w_s2_load;
    logic                 w_s3_load;

    logic                 r1_valid;
    logic                 r1_bad;
    logic                 r1_neg_l;
    logic                 r1_neg_r;
    logic [ROM_BITS-1:0]  r1_rom_l;
    logic [ROM_BITS-1:0]  r1_rom_r;

    logic                 r2_valid;
    logic                 r2_bad;
    logic                 r2_neg_l;
    logic                 r2_neg_r;
    logic [PROD_BITS-1:0] r2_prod_l;
    logic [PROD_BITS-1:0] r2_prod_r;

    logic                          r3_valid;
    logic                          r3_bad;
    logic signed [SAMPLE_BITS-1:0] r3_left;
    logic signed [SAMPLE_BITS-1:0] r3_right;

    // stage enables: a stage loads when it is empty or its successor moves
    assign w_s3_load = !r3_valid || o_sample.ready;
    assign w_s2_load = !r2_valid || w_s3_load;
    assign w_s1_load = !r1_valid || w_s2_load;
    assign o_q_ready = w_s1_load;

    // job decode
    assign w_top_l  = i_q_data[2*TOP_BITS-1 -: TOP_BITS];
    assign w_top_r  = i_q_data[TOP_BITS-1:0];
    assign w_addr_l = table_addr(w_top_l);
    assign w_addr_r = table_addr(w_top_r);

    // stage 1: table read
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r1_bad   <= i_q_data[2*TOP_BITS];
            r1_neg_l <= w_top_l[TOP_BITS-1] ^ w_top_l[TOP_BITS-2];
            r1_neg_r <= w_top_r[TOP_BITS-1] ^ w_top_r[TOP_BITS-2];
            r1_rom_l <= ROM_IMG[w_addr_l];
            r1_rom_r <= ROM_IMG[w_addr_r];
        end
    end

    // stage 2: gain multiply
    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r2_bad    <= r1_bad;
            r2_neg_l  <= r1_neg_l;
            r2_neg_r  <= r1_neg_r;
            r2_prod_l <= PROD_BITS'(i_gain.left_gain) * PROD_BITS'(r1_rom_l);
            r2_prod_r <= PROD_BITS'(i_gain.right_gain) * PROD_BITS'(r1_rom_r);
        end
    end

    // stage 3: round, sign, zero for a bad beat
    always_ff @(posedge i_clk) begin
        if (w_s3_load) begin
            r3_bad   <= r2_bad;
            r3_left  <= r2_bad ? '0 : finish(r2_prod_l, r2_neg_l);
            r3_right <= r2_bad ? '0 : finish(r2_prod_r, r2_neg_r);
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r1_valid <= i_q_valid;
            end
            if (w_s2_load) begin
                r2_valid <= r1_valid;
            end
            if (w_s3_load) begin
                r3_valid <= r2_valid;
            end
        end
    end

    assign o_sample.valid        = r3_valid;
    assign o_sample.left_sample  = r3_left;
    assign o_sample.right_sample = r3_right;
    assign o_sample.bad_message  = r3_bad;

endmodule

[rtl/core/stereo_tone_dds.sv]
// stereo_tone_dds: two channel cosine tone generator, one sample pair per beat
// a taken tick is queued, then passes the table read, multiply and output
// registers before its pair appears on o_sample
// one tick per cycle while the queue has room; one table read per channel
// reset: synchronous active low, clears phases, registers, queue and pipeline
module stereo_tone_dds
    import stdds_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    stdds_tick_if.sink               i_tick,
    stdds_sample_if.source           o_sample,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int ENTRY_BITS = 2 * (TABLE_ADDR_BITS + 2) + 1;

    t_gain_pair            w_gain;
    logic                  w_push_valid;
    logic                  w_push_ready;
    logic [ENTRY_BITS-1:0] w_push_data;
    logic                  w_pop_valid;
    logic                  w_pop_ready;
    logic [ENTRY_BITS-1:0] w_pop_data;

    // front: registers, phases, classification
    stdds_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (i_tick),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_gain     (w_gain),
        .o_q_valid  (w_push_valid),
        .i_q_ready  (w_push_ready),
        .o_q_data   (w_push_data)
    );

    // job queue
    stdds_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // back: table, multiply, output
    stdds_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain    (w_gain),
        .i_q_valid (w_pop_valid),
        .o_q_ready (w_pop_ready),
        .i_q_data  (w_pop_data),
        .o_sample  (o_sample)
    );

`ifndef SYNTHESIS
    // a bad beat carries silence on both channels
    a_bad_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample.valid && o_sample.bad_message |->
            o_sample.left_sample == '0 && o_sample.right_sample == '0)
        else $error("bad beat with non-zero samples");

    // a job held back by the pipeline stays at the queue head unchanged
    a_queue_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_valid && !w_pop_ready |=> w_pop_valid && $stable(w_pop_data))
        else $error("queue head lost or changed while stalled");

    // the front only stalls when the queue is holding jobs
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_push_ready |-> w_pop_valid)
        else $error("tick stalled with an empty queue");
`endif

endmodule

[tb/tb_stereo_tone_dds.sv]
// tb_stereo_tone_dds: self-checking bench for the stereo cosine tone generator
// drives ticks and register writes, predicts each sample pair and checks every beat
// depends on stdds_pkg, stdds_tick_if, stdds_sample_if and stereo_tone_dds
module tb_stereo_tone_dds;
    import stdds_pkg::*;

    localparam int PB  = PHASE_BITS_DEF;
    localparam int TAB = TABLE_ADDR_BITS_DEF;
    localparam int SB  = SAMPLE_BITS_DEF;
    // product of gain and table entry is 15 + 31 bits wide, with 30 fraction bits
    localparam int PSH = 46 - SB;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30         = 64'd1 << 30;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 bad;
    } tone_pair_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    stdds_tick_if                       tick_ch ();
    stdds_sample_if #(.SAMPLE_BITS(SB)) smp_ch ();

    stereo_tone_dds #(
        .PHASE_BITS      (PB),
        .TABLE_ADDR_BITS (TAB),
        .SAMPLE_BITS     (SB)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_ch),
        .o_sample   (smp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state: quarter-wave cosine, registers and phase accumulators
    logic [30:0]          cos_tab [0:(1 << TAB)];
    logic [STEP_BITS-1:0] lstep  = '0;
    logic [STEP_BITS-1:0] rstep  = '0;
    logic [GAIN_BITS-1:0] lgain  = '0;
    logic [GAIN_BITS-1:0] rgain  = '0;
    logic [PB-1:0]        lphase = '0;
    logic [PB-1:0]        rphase = '0;

    tone_pair_t  pending_pairs [$];
    int unsigned fail_count  = 0;
    int unsigned tx_max_gap  = 11;
    int unsigned rx_max_stall = 11;
    int unsigned rx_hold_req = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cosine of one channel's phase scaled by its gain, rounded half up
    function automatic logic signed [SB-1:0] tone_level(input logic [PB-1:0] phase,
                                                        input logic [GAIN_BITS-1:0] gain);
        logic [TAB+1:0]    top;
        logic [TAB-1:0]    q;
        logic [1:0]        quad;
        int unsigned       addr;
        longint unsigned   prod;
        longint unsigned   mag;
        logic [SB-1:0]     level;
        top   = phase[PB-1 -: TAB+2];
        q     = top[TAB-1:0];
        quad  = top[TAB+1:TAB];
        addr  = quad[0] ? ((1 << TAB) - int'(q)) : int'(q);
        prod  = 64'(gain) * 64'(cos_tab[addr]);
        mag   = (prod + (64'd1 << (PSH - 1))) >> PSH;
        level = mag[SB-1:0];
        if (quad == 2'd1 || quad == 2'd2) begin
            level = -level;
        end
        return level;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (fail_count < 30) begin
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        end
        fail_count++;
    endtask

    // one register write; the enable stays up for back-to-back writes
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LEFT_STEP:  lstep = data[STEP_BITS-1:0];
            CFG_RIGHT_STEP: rstep = data[STEP_BITS-1:0];
            CFG_LEFT_GAIN:  lgain = data[GAIN_BITS-1:0];
            CFG_RIGHT_GAIN: rgain = data[GAIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] ls, input logic [31:0] rs,
                                input logic [GAIN_BITS-1:0] lg,
                                input logic [GAIN_BITS-1:0] rg);
        write_reg(CFG_LEFT_STEP, ls);
        write_reg(CFG_RIGHT_STEP, rs);
        write_reg(CFG_LEFT_GAIN, CFG_DATA_BITS'(lg));
        write_reg(CFG_RIGHT_GAIN, CFG_DATA_BITS'(rg));
        i_cfg_we <= 1'b0;
    endtask

    // offer one beat; valid stays high into the next call when no gap is drawn
    task automatic offer_tick(input logic tick);
        int unsigned gap;
        tone_pair_t  want;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.is_tick <= tick;
        do @(posedge i_clk); while (!tick_ch.ready);
        // pair for this beat, then step the phases on a real tick only
        if (tick) begin
            want.left  = tone_level(lphase, lgain);
            want.right = tone_level(rphase, rgain);
            want.bad   = 1'b0;
            lphase     = lphase + PB'(lstep);
            rphase     = rphase + PB'(rstep);
        end else begin
            want.left  = '0;
            want.right = '0;
            want.bad   = 1'b1;
        end
        pending_pairs.push_back(want);
    endtask

    task automatic await_all_pairs();
        tick_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] draw_step();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 32'h00FF_FFFF));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] draw_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return GAIN_BITS'($urandom());
        endcase
    endfunction

    // gains are still zero after reset, so every pair is silent
    task automatic test_reset_defaults();
        offer_tick(1'b1);
        offer_tick(1'b1);
        offer_tick(1'b0);
        await_all_pairs();
    endtask

    // quarter and eighth turn steps at full gain visit every quadrant and its edges
    task automatic test_quadrant_walk();
        program_regs(32'h4000_0000, 32'h2000_0000, '1, '1);
        repeat (9) offer_tick(1'b1);
        await_all_pairs();
    endtask

    // non-tick beats give zeros and the flag without moving the phases
    task automatic test_non_tick_items();
        program_regs(32'h0123_4567, 32'hFEDC_BA98, 15'd1, 15'h4000);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b1);
        await_all_pairs();
    endtask

    // largest step wraps backwards, zero step holds the phase
    task automatic test_step_extremes();
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, '1, 15'd1);
        repeat (6) offer_tick(1'b1);
        await_all_pairs();
    endtask

    // several random settings, each with its own idling pattern
    task automatic test_random_tones();
        for (int ph = 0; ph < 8; ph++) begin
            program_regs(draw_step(), draw_step(), draw_gain(), draw_gain());
            case ($urandom_range(0, 3))
                0: begin tx_max_gap = 11; rx_max_stall = 11; end
                1: begin tx_max_gap = 0;  rx_max_stall = 0;  end
                2: begin tx_max_gap = 0;  rx_max_stall = 11; end
                default: begin tx_max_gap = 11; rx_max_stall = 0; end
            endcase
            for (int n = 0; n < 48; n++) begin
                offer_tick($urandom_range(0, 9) != 0);
            end
            await_all_pairs();
        end
        tx_max_gap   = 11;
        rx_max_stall = 11;
    endtask

    // long receiver hold-off while ticks keep coming, so the input stalls
    task automatic test_output_hold_off();
        program_regs(draw_step(), draw_step(), draw_gain(), draw_gain());
        tx_max_gap   = 0;
        rx_max_stall = 0;
        rx_hold_req  = 200;
        repeat (24) offer_tick(1'b1);
        await_all_pairs();
        tx_max_gap   = 11;
        rx_max_stall = 11;
    endtask

    // sender stops until every pair is back, then carries on
    task automatic test_sender_pause();
        program_regs(draw_step(), draw_step(), draw_gain(), draw_gain());
        repeat (10) offer_tick($urandom_range(0, 9) != 0);
        await_all_pairs();
        repeat (10) offer_tick($urandom_range(0, 9) != 0);
        await_all_pairs();
    endtask

    // receiver: random stalls per beat, plus a long hold-off on request
    initial begin : sample_sink
        int unsigned wait_cycles;
        int unsigned held;
        smp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, rx_max_stall);
            if (rx_hold_req != 0) begin
                wait_cycles = rx_hold_req;
                rx_hold_req = 0;
            end
            if (wait_cycles != 0) begin
                smp_ch.ready <= 1'b0;
                for (held = 0; held < wait_cycles; held++) @(posedge i_clk);
            end
            smp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!smp_ch.valid);
        end
    end

    // compare every sample beat with the oldest pending pair
    always @(posedge i_clk) begin
        tone_pair_t want;
        if (i_rst_n && smp_ch.valid && smp_ch.ready) begin
            if (pending_pairs.size() == 0) begin
                flag_mismatch("sample beat with nothing pending", 1, 0);
            end else begin
                want = pending_pairs.pop_front();
                if (smp_ch.left_sample !== want.left) begin
                    flag_mismatch("left_sample", smp_ch.left_sample, want.left);
                end
                if (smp_ch.right_sample !== want.right) begin
                    flag_mismatch("right_sample", smp_ch.right_sample, want.right);
                end
                if (smp_ch.bad_message !== want.bad) begin
                    flag_mismatch("bad_message", smp_ch.bad_message, want.bad);
                end
            end
        end
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint          acc;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_LEFT_STEP;
        i_cfg_data      <= '0;
        tick_ch.valid   <= 1'b0;
        tick_ch.is_tick <= 1'b0;

        // quarter-wave cosine by truncated taylor series, last entry forced to zero
        for (int q = 0; q <= (1 << TAB); q++) begin
            x   = (QUARTER_TURN_Q30 * 64'(q)) >> TAB;
            x2  = (x * x) >> 30;
            mag = UNIT_Q30;
            acc = longint'(UNIT_Q30);
            for (int k = 1; k <= 12; k++) begin
                mag = ((mag * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    acc = acc - longint'(mag);
                end else begin
                    acc = acc + longint'(mag);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(UNIT_Q30)) begin
                acc = longint'(UNIT_Q30);
            end
            cos_tab[q] = 31'(acc);
        end
        cos_tab[1 << TAB] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_quadrant_walk();
        test_non_tick_items();
        test_step_extremes();
        test_random_tones();
        test_output_hold_off();
        test_sender_pause();

        // let any stray beat show up before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
